[sv/rsm_pkg.sv]
// shared constants, marker table and compare function for the save marker scanner
`timescale 1ns / 1ps
`default_nettype none

package rsm_pkg;

    localparam int HIST_DEPTH   = 9;
    localparam int WIN_LEN      = HIST_DEPTH + 1;
    localparam int MARKER_COUNT = 5;

    typedef logic [7:0] byte_t;
    typedef logic [MARKER_COUNT-1:0] hit_t;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_FLASH64  = 3'd1,
        KIND_FLASH128 = 3'd2,
        KIND_SRAM     = 3'd3,
        KIND_EEPROM   = 3'd4
    } save_kind_t;

    // marker text right-aligned to the window, last char at the newest byte
    localparam byte_t MARKER_TEXT [MARKER_COUNT][WIN_LEN] = '{
        '{"F", "L", "A", "S", "H", "5", "1", "2", "_", "V"},
        '{8'h00, "F", "L", "A", "S", "H", "1", "M", "_", "V"},
        '{8'h00, 8'h00, 8'h00, "F", "L", "A", "S", "H", "_", "V"},
        '{8'h00, 8'h00, 8'h00, 8'h00, "S", "R", "A", "M", "_", "V"},
        '{8'h00, 8'h00, "E", "E", "P", "R", "O", "M", "_", "V"}
    };

    localparam int MARKER_LEN [MARKER_COUNT] = '{10, 9, 7, 6, 8};

    localparam save_kind_t MARKER_KIND [MARKER_COUNT] = '{
        KIND_FLASH64, KIND_FLASH128, KIND_FLASH64, KIND_SRAM, KIND_EEPROM
    };

    // per marker: byte at window position pos is fine for that marker
    function automatic hit_t byte_hits(input byte_t b, input int pos);
        hit_t h;
        h = '0;
        for (int k = 0; k < MARKER_COUNT; k++)
        begin
            if (pos < WIN_LEN - MARKER_LEN[k])
                h[k] = 1'b1;
            else
                h[k] = (b == MARKER_TEXT[k][pos]);
        end
        return h;
    endfunction

endpackage

`default_nettype wire

[sv/rsm_in_if.sv]
// image byte stream channel
`timescale 1ns / 1ps
`default_nettype none

interface rsm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] image_byte;
    logic       final_byte;

    modport source (output valid, output image_byte, output final_byte, input ready);
    modport sink (input valid, input image_byte, input final_byte, output ready);
endinterface

`default_nettype wire

[sv/rsm_out_if.sv]
// save kind result channel
`timescale 1ns / 1ps
`default_nettype none

interface rsm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] save_kind;

    modport source (output valid, output save_kind, input ready);
    modport sink (input valid, input save_kind, output ready);
endinterface

`default_nettype wire

[sv/rsm_cell.sv]
// one history cell: holds a byte, shifts it to its neighbor, compares it to the markers
`timescale 1ns / 1ps
`default_nettype none

module rsm_cell
    import rsm_pkg::*;
#(
    parameter int POS = 0
)
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        shift,
    input  wire        clear,
    input  wire byte_t byte_in,
    output byte_t      byte_out,
    output hit_t       hit
);

    byte_t byte_reg;
    byte_t byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
            byte_next = '0;
        else if (shift)
            byte_next = byte_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_reg <= '0;
        else
            byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;
    assign hit      = byte_hits(byte_reg, POS);

endmodule

`default_nettype wire

[sv/rom_save_marker_scanner.sv]
// top level: cell chain over the last nine bytes, sticky marker flags, result register
// latency: save kind is valid the cycle after the final byte beat
// throughput: one image byte per cycle; input stalls only while a result waits unread
// compare: nine history cells plus the incoming byte checked against all markers at once
// reset: rst_n clears history, flags and result valid asynchronously, not kind_reg
// a final byte beat also returns history and flags to their reset values
`timescale 1ns / 1ps
`default_nettype none

module rom_save_marker_scanner
    import rsm_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    rsm_in_if.sink      img,
    rsm_out_if.source   result
);

    byte_t hist [HIST_DEPTH];
    hit_t  cell_hit [HIST_DEPTH];
    hit_t  cur_hit;
    hit_t  match_now;
    hit_t  seen_reg;
    hit_t  seen_next;
    hit_t  seen_all;
    logic  out_valid_reg;
    logic  out_valid_next;
    save_kind_t kind_reg;
    save_kind_t kind_next;
    save_kind_t kind_pick;
    logic  take;
    logic  done;

    assign img.ready = !out_valid_reg || result.ready;
    assign take      = img.valid && img.ready;
    assign done      = take && img.final_byte;

    for (genvar i = 0; i < HIST_DEPTH; i++)
    begin : g_cell
        byte_t feed;
        if (i == HIST_DEPTH - 1)
        begin : g_head
            assign feed = img.image_byte;
        end
        else
        begin : g_body
            assign feed = hist[i+1];
        end

        rsm_cell #(
            .POS (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (take),
            .clear    (done),
            .byte_in  (feed),
            .byte_out (hist[i]),
            .hit      (cell_hit[i])
        );
    end

    assign cur_hit = byte_hits(img.image_byte, WIN_LEN - 1);

    always_comb
    begin
        match_now = cur_hit;
        for (int i = 0; i < HIST_DEPTH; i++)
            match_now = match_now & cell_hit[i];
    end

    assign seen_all = seen_reg | match_now;

    // marker order sets priority
    always_comb
    begin
        kind_pick = KIND_NONE;
        for (int k = MARKER_COUNT - 1; k >= 0; k--)
        begin
            if (seen_all[k])
                kind_pick = MARKER_KIND[k];
        end
    end

    always_comb
    begin
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (done)
        begin
            seen_next      = '0;
            out_valid_next = 1'b1;
            kind_next      = kind_pick;
        end
        else if (take)
        begin
            seen_next = seen_all;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.save_kind = kind_reg;

    a_result_follows_final: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> result.valid)
        else $error("no result after final byte beat");

    a_flags_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> seen_reg == '0)
        else $error("marker flags not cleared after final byte");

    a_history_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> hist[HIST_DEPTH-1] == '0 && hist[0] == '0)
        else $error("history not cleared after final byte");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.save_kind <= KIND_EEPROM)
        else $error("save kind out of range");

endmodule

`default_nettype wire

[tb/rsm_scan_checker.sv]
// checker for the save marker scanner: predicts each save kind and compares result beats
`timescale 1ns / 1ps

module rsm_scan_checker
    import rsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rsm_in_if           img,
    rsm_out_if          result,
    output int          fail_count,
    output int          pending,
    output int          kinds_compared,
    output logic [4:0]  kinds_seen
);

    // list order is the reporting priority
    string marker_text [5] = '{{"FLASH512", "_V"}, {"FLASH1M", "_V"}, "FLASH_V", "SRAM_V",
                               {"EEPROM", "_V"}};
    save_kind_t marker_kind [5] = '{KIND_FLASH64, KIND_FLASH128, KIND_FLASH64,
                                    KIND_SRAM, KIND_EEPROM};

    logic [71:0] recent_bytes;  // newest byte in the low lane
    logic [4:0]  found;
    save_kind_t  kind_q[$];

    function automatic bit window_ends_with(input logic [79:0] w, input string s);
        int  n;
        bit  ok;
        n  = s.len();
        ok = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (w[8*(n-1-i) +: 8] != s[i])
                ok = 1'b0;
        end
        return ok;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [79:0] win;
        save_kind_t  want;
        if (!rst_n)
        begin
            recent_bytes   = '0;
            found          = '0;
            kind_q.delete();
            fail_count     = 0;
            kinds_compared = 0;
            kinds_seen     = '0;
        end
        else
        begin
            // result beats first: a result never belongs to a byte taken at the same edge
            if (result.valid === 1'b1 && result.ready === 1'b1)
            begin
                if (kind_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: save kind beat with nothing expected, expected none, actual %0d",
                             $time, result.save_kind);
                end
                else
                begin
                    want = kind_q.pop_front();
                    kinds_compared++;
                    kinds_seen[want] = 1'b1;
                    if (result.save_kind !== want)
                    begin
                        fail_count++;
                        $display("%0t: save kind mismatch, expected %0d, actual %0d",
                                 $time, want, result.save_kind);
                    end
                end
            end
            if (img.valid === 1'b1 && img.ready === 1'b1)
            begin
                win = {recent_bytes, img.image_byte};
                for (int k = 0; k < 5; k++)
                begin
                    if (window_ends_with(win, marker_text[k]))
                        found[k] = 1'b1;
                end
                recent_bytes = win[71:0];
                if (img.final_byte)
                begin
                    want = KIND_NONE;
                    for (int k = 4; k >= 0; k--)
                    begin
                        if (found[k])
                            want = marker_kind[k];
                    end
                    kind_q.push_back(want);
                    recent_bytes = '0;
                    found        = '0;
                end
            end
        end
        pending = kind_q.size();
    end

endmodule

[tb/rom_save_marker_scanner_test.sv]
// top of the save marker scanner testbench: clock, reset, image stimulus and verdict
`timescale 1ns / 1ps

module rom_save_marker_scanner_test;
    import rsm_pkg::*;

    logic clk;
    logic rst_n;
    bit   calm;

    int          fail_count;
    int          pending;
    int          kinds_compared;
    logic [4:0]  kinds_seen;

    int          bytes_sent;
    int          images_sent;
    int          stall_left;
    logic [7:0]  image_q[$];

    string marker_text [5] = '{{"FLASH512", "_V"}, {"FLASH1M", "_V"}, "FLASH_V", "SRAM_V",
                               {"EEPROM", "_V"}};
    string letters = "VFLASH512_MSREOPD";

    rsm_in_if  img ();
    rsm_out_if result ();

    rom_save_marker_scanner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .img    (img),
        .result (result)
    );

    rsm_scan_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .img            (img),
        .result         (result),
        .fail_count     (fail_count),
        .pending        (pending),
        .kinds_compared (kinds_compared),
        .kinds_seen     (kinds_seen)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // mostly short idles, now and then a long one, none during calm stretches
    function automatic int idle_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    initial
    begin
        calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(50, 400)) @(negedge clk);
            calm = ($urandom_range(0, 3) == 0);
        end
    end

    // result side back-pressure
    initial
    begin
        stall_left = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                result.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_len(calm);
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input bit fin);
        int gap;
        gap = idle_len(calm);
        if (gap > 0)
        begin
            img.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        img.valid      <= 1'b1;
        img.image_byte <= b;
        img.final_byte <= fin;
        @(negedge clk);
        while (!img.ready)
            @(negedge clk);
        @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_image();
        for (int i = 0; i < image_q.size(); i++)
            send_beat(image_q[i], i == image_q.size() - 1);
        images_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            image_q.push_back(s[i]);
    endtask

    // hold the sender off until every expected save kind has come back
    task automatic drain();
        img.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic build_image();
        int    pieces;
        int    r;
        int    k;
        string m;
        image_q.delete();
        pieces = $urandom_range(0, 4);
        for (int p = 0; p < pieces; p++)
        begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, 4);
            m = marker_text[k];
            if (r < 35)
                add_text(m);
            else if (r < 55)
            begin
                // near miss: one byte of a marker replaced
                m[$urandom_range(0, m.len() - 1)] = letters[$urandom_range(0, letters.len() - 1)];
                add_text(m);
            end
            else if (r < 65)
                add_text(m.substr(0, $urandom_range(0, m.len() - 2)));
            else if (r < 85)
            begin
                repeat ($urandom_range(1, 5))
                    image_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    image_q.push_back(letters[$urandom_range(0, letters.len() - 1)]);
            end
        end
        if ($urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(30, 60))
                image_q.push_back(8'($urandom_range(0, 255)));
        end
        if (image_q.size() == 0)
            image_q.push_back(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        bytes_sent  = 0;
        images_sent = 0;
        rst_n          <= 1'b0;
        img.valid      <= 1'b0;
        img.image_byte <= 8'h00;
        img.final_byte <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // single byte image, all ones
        image_q.delete();
        image_q.push_back(8'hFF);
        send_image();
        image_q.delete();
        add_text("SRAM_V");
        send_image();
        // marker cut by the end of an image must not complete in the next one
        image_q.delete();
        add_text("FLASH512_");
        send_image();
        image_q.delete();
        add_text("V");
        send_image();
        image_q.delete();
        add_text(marker_text[4]);
        send_image();
        drain();

        while (bytes_sent < 1525)
        begin
            build_image();
            send_image();
            if ($urandom_range(0, 14) == 0)
                drain();
        end

        drain();
        repeat (4) @(posedge clk);
        @(negedge clk);
        $display("covered %0d image bytes in %0d images, %0d save kinds compared",
                 bytes_sent, images_sent, kinds_compared);
        $display("save kinds seen (bit per code, eeprom down to none): %b", kinds_seen);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d save kinds still expected", pending);
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
sv/rsm_pkg.sv
sv/rsm_in_if.sv
sv/rsm_out_if.sv
sv/rsm_cell.sv
sv/rom_save_marker_scanner.sv
tb/rsm_scan_checker.sv
tb/rom_save_marker_scanner_test.sv
